// File: rtl/core/differential_drive_odometry_macros.svh
// assertion macros for the odometry block
// used by the port checker; no other dependencies
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// property must hold at every clock edge outside reset
`define DDO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define DDO_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: rtl/core/ddo_pkg.sv
// shared types, constants and the arctangent table for the odometry block
// no dependencies
package ddo_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REM_W     = 44;  // dividend width of the remainder unit
  localparam int unsigned DIV_W     = 16;  // divisor width of the remainder unit
  localparam int unsigned MUL_W     = 34;  // operand width of the serial multiplier
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned CRD_W     = 34;  // cordic x/y width, q.30
  localparam int unsigned Z_W       = 28;  // cordic angle width, q.24
  localparam int unsigned ATAN_ENTRIES = 20;

  localparam logic [15:0] ANG_TWO_PI  = 16'd25736;
  localparam logic [15:0] ANG_PI      = 16'd12868;
  localparam logic [15:0] ANG_HALF_PI = 16'd6434;
  localparam logic signed [CRD_W-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [15:0] DPC_RESET    = 16'd256;
  localparam logic [15:0] IWB_RESET    = 16'd256;
  localparam logic [15:0] PERIOD_RESET = 16'd8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DPC    = 2'd0,
    CFG_IWB    = 2'd1,
    CFG_PERIOD = 2'd2
  } ddo_cfg_e;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        left_count;
    logic [15:0]        right_count;
    logic signed [15:0] heading;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } ddo_out_t;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_REM_L   = 11'b00000000010,
    S_REM_R   = 11'b00000000100,
    S_MUL_LEN = 11'b00000001000,
    S_MUL_TRN = 11'b00000010000,
    S_MUL_ROT = 11'b00000100000,
    S_REM_ANG = 11'b00001000000,
    S_CORDIC  = 11'b00010000000,
    S_MUL_X   = 11'b00100000000,
    S_MUL_Y   = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } ddo_state_e;

  // atan(2^-i) in q.24
  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/differential_drive_odometry.sv
// update request: three remainder passes, five serial multiplies, the cordic rotation
// and a load of the output register; a re-reference request goes straight to that load.
// one request in flight; the next is taken the cycle after the result register loads,
// and an output stall on the previous result holds off that load.
// reset clears position, stored counts and heading, and restores register defaults.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ddo_pkg::ddo_in_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ddo_pkg::ddo_out_t             out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import ddo_pkg::*;

  ddo_state_e state_q, state_d;
  logic       go_q, go_d;

  logic [15:0] dpc_q, iwb_q, per_q;
  logic [15:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic signed [15:0] prevh_q, head_q;
  logic signed [31:0] acc_x_q, acc_y_q;
  logic signed [16:0] dl_q, dr_q;
  logic signed [MUL_W-1:0] len_q, t_q;
  logic signed [44:0] ang_q;
  logic signed [15:0] zang_q;
  logic               neg_q;
  logic signed [CRD_W-1:0] cos_q, sin_q;
  logic       out_valid_q;
  ddo_out_t   out_q;

  // unit hookups
  logic               rem_start, rem_done;
  logic [REM_W-1:0]   rem_num;
  logic [DIV_W-1:0]   rem_div, rem_res;
  logic               mul_start, mul_done;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_prod;
  logic               crd_start, crd_done;
  logic signed [CRD_W-1:0] crd_cos, crd_sin;

  // wheel count differences
  logic [16:0] diff_l, diff_r;
  logic [15:0] mag_l, mag_r;
  logic signed [16:0] fold_d;
  logic signed [17:0] wsum, wdif;
  logic signed [16:0] hsum;
  logic signed [44:0] ang_d;
  logic [REM_W-1:0]   ang_abs;
  logic [15:0]        amod;
  logic signed [16:0] awrap;
  logic signed [15:0] afold;
  logic               aneg;
  logic signed [37:0] qprod;
  logic signed [31:0] acc_sel, acc_new;
  logic signed [38:0] acc_dif;
  logic               out_free, in_acc;

  assign diff_l = {1'b0, cur_l_q} - {1'b0, prev_l_q};
  assign diff_r = {1'b0, cur_r_q} - {1'b0, prev_r_q};
  assign mag_l  = diff_l[16] ? 16'(-diff_l) : diff_l[15:0];
  assign mag_r  = diff_r[16] ? 16'(-diff_r) : diff_r[15:0];

  // fold remainder to the signed step in (-P/2, P/2]
  function automatic logic signed [16:0] fold_step(input logic [15:0] r,
                                                   input logic neg,
                                                   input logic [15:0] p);
    logic [16:0] r2;
    logic signed [16:0] d;
    if (neg && (r != '0)) begin
      r2 = {1'b0, p} - {1'b0, r};
    end else begin
      r2 = {1'b0, r};
    end
    if ({r2, 1'b0} > {2'b0, p}) begin
      d = $signed(r2 - {1'b0, p});
    end else begin
      d = $signed(r2);
    end
    if (p < 16'd2) begin
      d = '0;
    end
    return d;
  endfunction

  always_comb begin
    if (state_q == S_REM_L) begin
      fold_d = fold_step(rem_res, diff_l[16], per_q);
    end else begin
      fold_d = fold_step(rem_res, diff_r[16], per_q);
    end
  end

  assign wsum = {dl_q[16], dl_q} + {dr_q[16], dr_q};
  assign wdif = {dr_q[16], dr_q} - {dl_q[16], dl_q};
  assign hsum = {head_q[15], head_q} + {prevh_q[15], prevh_q};
  assign ang_d = mul_prod[49:5] + {{29{hsum[16]}}, hsum[16:1]};
  assign ang_abs = ang_q[44] ? REM_W'(-ang_q) : ang_q[REM_W-1:0];

  // angle into (-pi, pi], then into [-pi/2, pi/2] with a sign flip
  always_comb begin
    if (ang_q[44] && (rem_res != '0)) begin
      amod = ANG_TWO_PI - rem_res;
    end else begin
      amod = rem_res;
    end
    if (amod > ANG_PI) begin
      awrap = $signed({1'b0, amod}) - $signed({1'b0, ANG_TWO_PI});
    end else begin
      awrap = $signed({1'b0, amod});
    end
    aneg = 1'b0;
    afold = awrap[15:0];
    if (awrap > $signed({1'b0, ANG_HALF_PI})) begin
      afold = 16'(awrap - $signed({1'b0, ANG_PI}));
      aneg  = 1'b1;
    end else if (awrap < -$signed({1'b0, ANG_HALF_PI})) begin
      afold = 16'(awrap + $signed({1'b0, ANG_PI}));
      aneg  = 1'b1;
    end
  end

  // subtract length * trig / 2^30 with saturation
  assign qprod   = mul_prod[PROD_W-1:30];
  assign acc_sel = (state_q == S_MUL_X) ? acc_x_q : acc_y_q;
  assign acc_dif = {{7{acc_sel[31]}}, acc_sel} - {qprod[37], qprod};
  always_comb begin
    if (acc_dif > 39'sd2147483647) begin
      acc_new = 32'sh7fffffff;
    end else if (acc_dif < -39'sd2147483648) begin
      acc_new = 32'sh80000000;
    end else begin
      acc_new = acc_dif[31:0];
    end
  end

  // operand selection for the shared units
  always_comb begin
    rem_num = {{(REM_W-16){1'b0}}, mag_l};
    rem_div = per_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_REM_R:   rem_num = {{(REM_W-16){1'b0}}, mag_r};
      S_REM_ANG: begin
        rem_num = ang_abs;
        rem_div = ANG_TWO_PI;
      end
      S_MUL_LEN: begin
        mul_a = {{(MUL_W-18){wsum[17]}}, wsum};
        mul_b = {{(MUL_W-16){1'b0}}, dpc_q};
      end
      S_MUL_TRN: begin
        mul_a = {{(MUL_W-18){wdif[17]}}, wdif};
        mul_b = {{(MUL_W-16){1'b0}}, dpc_q};
      end
      S_MUL_ROT: begin
        mul_a = t_q;
        mul_b = {{(MUL_W-16){1'b0}}, iwb_q};
      end
      S_MUL_X: begin
        mul_a = len_q;
        mul_b = cos_q;
      end
      S_MUL_Y: begin
        mul_a = len_q;
        mul_b = sin_q;
      end
      default: ;
    endcase
  end

  assign rem_start = go_q && ((state_q == S_REM_L) || (state_q == S_REM_R)
                              || (state_q == S_REM_ANG));
  assign mul_start = go_q && ((state_q == S_MUL_LEN) || (state_q == S_MUL_TRN)
                              || (state_q == S_MUL_ROT) || (state_q == S_MUL_X)
                              || (state_q == S_MUL_Y));
  assign crd_start = go_q && (state_q == S_CORDIC);

  ddo_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_num),
    .divisor_i  (rem_div),
    .done_o     (rem_done),
    .rem_o      (rem_res)
  );

  ddo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crd_start),
    .angle_i (zang_q),
    .done_o  (crd_done),
    .cos_o   (crd_cos),
    .sin_o   (crd_sin)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = in_req_i.cmd ? S_REM_L : S_DONE;
          go_d    = in_req_i.cmd;
        end
      end
      S_REM_L:   if (rem_done) begin state_d = S_REM_R;   go_d = 1'b1; end
      S_REM_R:   if (rem_done) begin state_d = S_MUL_LEN; go_d = 1'b1; end
      S_MUL_LEN: if (mul_done) begin state_d = S_MUL_TRN; go_d = 1'b1; end
      S_MUL_TRN: if (mul_done) begin state_d = S_MUL_ROT; go_d = 1'b1; end
      S_MUL_ROT: if (mul_done) begin state_d = S_REM_ANG; go_d = 1'b1; end
      S_REM_ANG: if (rem_done) begin state_d = S_CORDIC;  go_d = 1'b1; end
      S_CORDIC:  if (crd_done) begin state_d = S_MUL_X;   go_d = 1'b1; end
      S_MUL_X:   if (mul_done) begin state_d = S_MUL_Y;   go_d = 1'b1; end
      S_MUL_Y:   if (mul_done) begin state_d = S_DONE; end
      S_DONE:    if (out_free) begin state_d = S_IDLE; end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      dpc_q       <= DPC_RESET;
      iwb_q       <= IWB_RESET;
      per_q       <= PERIOD_RESET;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      prevh_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DPC:    dpc_q <= cfg_data_i;
          CFG_IWB:    iwb_q <= cfg_data_i;
          CFG_PERIOD: per_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == S_MUL_X) && mul_done) begin
        acc_x_q <= acc_new;
      end
      if ((state_q == S_MUL_Y) && mul_done) begin
        acc_y_q <= acc_new;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        prev_l_q    <= cur_l_q;
        prev_r_q    <= cur_r_q;
        prevh_q     <= head_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_l_q <= in_req_i.left_count;
      cur_r_q <= in_req_i.right_count;
      head_q  <= in_req_i.heading;
    end
    if ((state_q == S_REM_L) && rem_done) begin
      dl_q <= fold_d;
    end
    if ((state_q == S_REM_R) && rem_done) begin
      dr_q <= fold_d;
    end
    if ((state_q == S_MUL_LEN) && mul_done) begin
      len_q <= mul_prod[MUL_W:1];
    end
    if ((state_q == S_MUL_TRN) && mul_done) begin
      t_q <= mul_prod[MUL_W-1:0];
    end
    if ((state_q == S_MUL_ROT) && mul_done) begin
      ang_q <= ang_d;
    end
    if ((state_q == S_REM_ANG) && rem_done) begin
      zang_q <= afold;
      neg_q  <= aneg;
    end
    if ((state_q == S_CORDIC) && crd_done) begin
      cos_q <= neg_q ? -crd_cos : crd_cos;
      sin_q <= neg_q ? -crd_sin : crd_sin;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_q.pos_x <= acc_x_q;
      out_q.pos_y <= acc_y_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: rtl/core/ddo_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on ddo_pkg
module ddo_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ddo_pkg::REM_W-1:0] dividend_i,
  input  logic [ddo_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ddo_pkg::DIV_W-1:0] rem_o
);
  import ddo_pkg::*;

  localparam int unsigned CNT_W = $clog2(REM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] num_q;
  logic [DIV_W-1:0] div_q, r_q, r_d;
  logic [DIV_W:0]   trial;

  always_comb begin
    trial = {r_q, num_q[REM_W-1]};
    if (trial >= {1'b0, div_q}) begin
      r_d = DIV_W'(trial - {1'b0, div_q});
    end else begin
      r_d = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(REM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      r_q   <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[REM_W-2:0], 1'b0};
      r_q   <= r_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// File: rtl/core/ddo_mul.sv
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
// depends on ddo_pkg
module ddo_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ddo_pkg::MUL_W-1:0]  a_i,
  input  logic signed [ddo_pkg::MUL_W-1:0]  b_i,
  output logic                              done_o,
  output logic signed [ddo_pkg::PROD_W-1:0] prod_o
);
  import ddo_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_W);

  logic                    busy_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [MUL_W-1:0] a_q;
  logic signed [MUL_W:0]   hi_q, addend, sum;
  logic [MUL_W-1:0]        lo_q;

  always_comb begin
    addend = lo_q[0] ? {a_q[MUL_W-1], a_q} : '0;
    // top bit of the multiplier carries negative weight
    if (cnt_q == '0) begin
      sum = hi_q - addend;
    end else begin
      sum = hi_q + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MUL_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= {sum[MUL_W], sum[MUL_W:1]};
      lo_q <= {sum[0], lo_q[MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[MUL_W-1:0], lo_q};

endmodule

// File: rtl/core/ddo_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on ddo_pkg
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [15:0]               angle_i,
  output logic                             done_o,
  output logic signed [ddo_pkg::CRD_W-1:0] cos_o,
  output logic signed [ddo_pkg::CRD_W-1:0] sin_o
);
  import ddo_pkg::*;

  localparam int unsigned NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  logic                    busy_q, done_q;
  logic [4:0]              cnt_q;
  logic signed [CRD_W-1:0] x_q, y_q, xs, ys;
  logic signed [Z_W-1:0]   z_q, at;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = $signed({{(Z_W-24){1'b0}}, atan_q24(cnt_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'(NSTEP - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'(NSTEP - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_X0;
      y_q <= '0;
      z_q <= {angle_i, 12'b0};
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

endmodule

// File: rtl/core/ddo_checker.sv
// port-level checks for the odometry block, bound to the top level
// depends on differential_drive_odometry_macros.svh
`include "differential_drive_odometry_macros.svh"

module ddo_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // an accepted request always leaves the block busy in the following cycle
  `DDO_ASSERT(a_busy_after_req, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "block idle right after a request")

  `DDO_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped while stalled")

  // a result only appears after the block has been working on a request
  `DDO_NEVER(a_no_spurious_out, clk_i, rst_ni, $rose(out_valid_o) && !$past(in_stall_o), "result without a request")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
